// File: sv/krt_pkg.sv
`timescale 1ns / 1ps
// krt_pkg: shared types and constants of the keyed record table
// no dependencies

package krt_pkg;

	localparam int ENTRIES = 16;
	localparam int POS_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_FULL = 2'd1,
		STS_MISS = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SEARCH,
		ST_SHIFT,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t         operation;
		logic [63:0] key_upper;
		logic [23:0] key_lower;
		logic [63:0] given_name_a;
		logic [63:0] given_name_b;
		logic [31:0] given_name_c;
		logic [63:0] family_name_a;
		logic [63:0] family_name_b;
		logic [31:0] family_name_c;
		logic [3:0]  read_position;
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [3:0]  found_position;
		logic [63:0] out_key_upper;
		logic [23:0] out_key_lower;
		logic [63:0] out_given_a;
		logic [63:0] out_given_b;
		logic [31:0] out_given_c;
		logic [63:0] out_family_a;
		logic [63:0] out_family_b;
		logic [31:0] out_family_c;
		logic [4:0]  occupied_count;
	} res_t;

	typedef struct packed {
		logic [63:0] key_upper;
		logic [23:0] key_lower;
		logic [63:0] given_a;
		logic [63:0] given_b;
		logic [31:0] given_c;
		logic [63:0] family_a;
		logic [63:0] family_b;
		logic [31:0] family_c;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/krt_ram.sv
`timescale 1ns / 1ps
// krt_ram: generic single write port, single read port ram with registered read
// no dependencies

module krt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/keyed_record_table_unit.sv
`timescale 1ns / 1ps
// keyed_record_table_unit: top level of the keyed record table
// depends on krt_pkg and krt_ram

// Table of ENTRIES records, each an 11-byte key and two 20-byte names, held in
// one ram with one read and one write port. The table is empty after reset and
// entries at or above the occupancy count read as zero. Find and remove walk
// the occupied entries one per cycle through the single ram read port and key
// comparator; remove then moves the entries after the match down one per cycle
// over the same port. One item is in work at a time; cmd_stall is high until
// its result is handed to the output register.

module keyed_record_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  krt_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output krt_pkg::res_t res
);

	import krt_pkg::*;

	state_t            st_q;
	state_t            st_d;
	op_t               op_q;
	logic [63:0]       key_u_q;
	logic [23:0]       key_l_q;
	logic [POS_W-1:0]  idx_q;
	logic [POS_W-1:0]  idx_d;
	logic              idx_ld;
	logic [CNT_W-1:0]  cnt_q;
	logic              cnt_inc;
	logic              cnt_dec;
	res_t              res_q;
	res_t              res_d;
	logic              res_ld;
	res_t              res_out_q;
	logic              out_valid_q;
	logic              out_ld;

	logic              cmd_acc;
	logic              more;
	logic              key_hit;
	logic              rd_pos_ok;
	logic              rd_pos_used;

	logic              wr_en;
	logic [POS_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic              rd_en;
	logic [POS_W-1:0]  rd_addr;
	entry_t            rd_data;

	function automatic res_t mk_res(status_t s, logic [POS_W-1:0] p, entry_t e,
			logic [CNT_W-1:0] n);
		res_t r;
		r.status         = s;
		r.found_position = 4'(p);
		r.out_key_upper  = e.key_upper;
		r.out_key_lower  = e.key_lower;
		r.out_given_a    = e.given_a;
		r.out_given_b    = e.given_b;
		r.out_given_c    = e.given_c;
		r.out_family_a   = e.family_a;
		r.out_family_b   = e.family_b;
		r.out_family_c   = e.family_c;
		r.occupied_count = 5'(n);
		return r;
	endfunction

	krt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign cmd_stall   = (st_q != ST_IDLE);
	assign cmd_acc     = cmd_valid && !cmd_stall;
	assign more        = ((CNT_W'(idx_q) + CNT_W'(1)) < cnt_q);
	assign key_hit     = (rd_data.key_upper == key_u_q) && (rd_data.key_lower == key_l_q);
	assign rd_pos_ok   = (32'(cmd.read_position) < ENTRIES);
	assign rd_pos_used = (32'(cmd.read_position) < 32'(cnt_q));
	assign res_valid   = out_valid_q;
	assign res         = res_out_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (cmd_acc) begin
					unique case (cmd.operation) inside
						OP_ADD: st_d = ST_DONE;
						OP_READ: st_d = (rd_pos_ok && rd_pos_used) ? ST_READ : ST_DONE;
						OP_FIND, OP_REMOVE: st_d = (cnt_q == '0) ? ST_DONE : ST_SEARCH;
						default: st_d = ST_DONE;
					endcase
				end
			end
			ST_READ: st_d = ST_DONE;
			ST_SEARCH: begin
				if (key_hit) begin
					st_d = (op_q == OP_REMOVE && more) ? ST_SHIFT : ST_DONE;
				end else if (!more) begin
					st_d = ST_DONE;
				end
			end
			ST_SHIFT: begin
				if (!more) begin
					st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !res_stall) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q - POS_W'(1);
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = idx_q + POS_W'(1);
		idx_ld  = 1'b0;
		idx_d   = idx_q + POS_W'(1);
		cnt_inc = 1'b0;
		cnt_dec = 1'b0;
		res_ld  = 1'b0;
		res_d   = mk_res(STS_MISS, '0, '0, cnt_q);
		out_ld  = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				idx_ld = cmd_acc;
				idx_d  = '0;
				if (cmd_acc) begin
					unique case (cmd.operation) inside
						OP_ADD: begin
							res_ld = 1'b1;
							if (cnt_q >= CNT_W'(ENTRIES)) begin
								res_d = mk_res(STS_FULL, '0, '0, cnt_q);
							end else begin
								wr_en            = 1'b1;
								wr_addr          = cnt_q[POS_W-1:0];
								wr_data.key_upper = cmd.key_upper;
								wr_data.key_lower = cmd.key_lower;
								wr_data.given_a  = cmd.given_name_a;
								wr_data.given_b  = cmd.given_name_b;
								wr_data.given_c  = cmd.given_name_c;
								wr_data.family_a = cmd.family_name_a;
								wr_data.family_b = cmd.family_name_b;
								wr_data.family_c = cmd.family_name_c;
								cnt_inc          = 1'b1;
								res_d = mk_res(STS_OK, cnt_q[POS_W-1:0], wr_data,
									cnt_q + CNT_W'(1));
							end
						end
						OP_READ: begin
							idx_d   = POS_W'(cmd.read_position);
							rd_addr = POS_W'(cmd.read_position);
							if (!rd_pos_ok) begin
								res_ld = 1'b1;
							end else if (!rd_pos_used) begin
								res_ld = 1'b1;
								res_d  = mk_res(STS_OK, POS_W'(cmd.read_position), '0, cnt_q);
							end else begin
								rd_en = 1'b1;
							end
						end
						OP_FIND, OP_REMOVE: begin
							rd_addr = '0;
							if (cnt_q == '0) begin
								res_ld = 1'b1;
							end else begin
								rd_en = 1'b1;
							end
						end
						default: res_ld = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				res_ld = 1'b1;
				res_d  = mk_res(STS_OK, idx_q, rd_data, cnt_q);
			end
			ST_SEARCH: begin
				if (key_hit) begin
					res_ld = 1'b1;
					if (op_q == OP_REMOVE) begin
						res_d = mk_res(STS_OK, idx_q, rd_data, cnt_q - CNT_W'(1));
						if (more) begin
							rd_en  = 1'b1;
							idx_ld = 1'b1;
						end else begin
							cnt_dec = 1'b1;
						end
					end else begin
						res_d = mk_res(STS_OK, idx_q, rd_data, cnt_q);
					end
				end else if (more) begin
					rd_en  = 1'b1;
					idx_ld = 1'b1;
				end else begin
					res_ld = 1'b1;
				end
			end
			ST_SHIFT: begin
				wr_en = 1'b1;
				if (more) begin
					rd_en  = 1'b1;
					idx_ld = 1'b1;
				end else begin
					cnt_dec = 1'b1;
				end
			end
			ST_DONE: begin
				out_ld = !out_valid_q || !res_stall;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (res_stall == 1'b0) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			op_q    <= cmd.operation;
			key_u_q <= cmd.key_upper;
			key_l_q <= cmd.key_lower;
		end
		if (idx_ld) begin
			idx_q <= idx_d;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		if (out_ld) begin
			res_out_q <= res_q;
		end
	end

endmodule

// File: tb/keyed_record_table_unit_tb.sv
`timescale 1ns / 1ps
// keyed_record_table_unit_tb: self-checking bench for the keyed record table
// scoreboard class keeps its own copy of the table and predicts every result
// depends on krt_pkg and keyed_record_table_unit

module keyed_record_table_unit_tb;

	import krt_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RAND_ITEMS  = 1000;
	localparam int LIMIT       = 400000;
	localparam int DRAIN       = 40;
	localparam int HOLD_CYCLES = 600;

	class record_table_scoreboard;
		entry_t rows[ENTRIES];
		int     count;
		res_t   pending_results[$];
		int     errors;
		int     mismatches;

		function new();
			foreach (rows[i]) rows[i] = '0;
			count      = 0;
			errors     = 0;
			mismatches = 0;
		endfunction

		function int find_row(logic [63:0] ku, logic [23:0] kl);
			for (int i = 0; i < count; i++) begin
				if (rows[i].key_upper == ku && rows[i].key_lower == kl) return i;
			end
			return -1;
		endfunction

		function res_t row_result(int pos);
			res_t r;
			r                = '0;
			r.status         = STS_OK;
			r.found_position = pos[3:0];
			r.out_key_upper  = rows[pos].key_upper;
			r.out_key_lower  = rows[pos].key_lower;
			r.out_given_a    = rows[pos].given_a;
			r.out_given_b    = rows[pos].given_b;
			r.out_given_c    = rows[pos].given_c;
			r.out_family_a   = rows[pos].family_a;
			r.out_family_b   = rows[pos].family_b;
			r.out_family_c   = rows[pos].family_c;
			return r;
		endfunction

		function void note_command(cmd_t c);
			res_t r;
			int   pos;
			r = '0;
			case (c.operation)
				OP_ADD: begin
					if (count >= ENTRIES) begin
						r.status = STS_FULL;
					end else begin
						rows[count].key_upper = c.key_upper;
						rows[count].key_lower = c.key_lower;
						rows[count].given_a   = c.given_name_a;
						rows[count].given_b   = c.given_name_b;
						rows[count].given_c   = c.given_name_c;
						rows[count].family_a  = c.family_name_a;
						rows[count].family_b  = c.family_name_b;
						rows[count].family_c  = c.family_name_c;
						r = row_result(count);
						count++;
					end
				end
				OP_FIND: begin
					pos = find_row(c.key_upper, c.key_lower);
					if (pos < 0) r.status = STS_MISS;
					else r = row_result(pos);
				end
				OP_REMOVE: begin
					pos = find_row(c.key_upper, c.key_lower);
					if (pos < 0) begin
						r.status = STS_MISS;
					end else begin
						r = row_result(pos);
						for (int i = pos + 1; i < count; i++) rows[i - 1] = rows[i];
						count--;
						rows[count] = '0;
					end
				end
				default: begin
					pos = int'(c.read_position);
					if (pos >= ENTRIES) r.status = STS_MISS;
					else r = row_result(pos);
				end
			endcase
			r.occupied_count = count[4:0];
			pending_results.push_back(r);
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			errors++;
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch %s: expected %h, got %h", $realtime, field, want, got);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				report("unexpected result, status", '0, 64'(got.status));
				return;
			end
			want = pending_results.pop_front();
			if (want.status !== got.status)
				report("status", 64'(want.status), 64'(got.status));
			if (want.found_position !== got.found_position)
				report("found_position", 64'(want.found_position), 64'(got.found_position));
			if (want.out_key_upper !== got.out_key_upper)
				report("out_key_upper", want.out_key_upper, got.out_key_upper);
			if (want.out_key_lower !== got.out_key_lower)
				report("out_key_lower", 64'(want.out_key_lower), 64'(got.out_key_lower));
			if (want.out_given_a !== got.out_given_a)
				report("out_given_a", want.out_given_a, got.out_given_a);
			if (want.out_given_b !== got.out_given_b)
				report("out_given_b", want.out_given_b, got.out_given_b);
			if (want.out_given_c !== got.out_given_c)
				report("out_given_c", 64'(want.out_given_c), 64'(got.out_given_c));
			if (want.out_family_a !== got.out_family_a)
				report("out_family_a", want.out_family_a, got.out_family_a);
			if (want.out_family_b !== got.out_family_b)
				report("out_family_b", want.out_family_b, got.out_family_b);
			if (want.out_family_c !== got.out_family_c)
				report("out_family_c", 64'(want.out_family_c), 64'(got.out_family_c));
			if (want.occupied_count !== got.occupied_count)
				report("occupied_count", 64'(want.occupied_count), 64'(got.occupied_count));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_go;
	logic hold_on;

	record_table_scoreboard sb;

	keyed_record_table_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #HALF_PERIOD clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) sb.note_command(cmd);
			if (res_valid && !res_stall) sb.check_result(res);
		end
	end

	always @(negedge clk) begin
		res_stall <= hold_on || ($urandom_range(99) < recv_stall_pct);
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		hold_on = 1'b0;
		wait (hold_go);
		@(negedge clk);
		hold_on <= 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on <= 1'b0;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic cmd_t random_cmd(int add_pct);
		cmd_t c;
		int   pick;
		int   row;
		c.given_name_a  = {$urandom(), $urandom()};
		c.given_name_b  = {$urandom(), $urandom()};
		c.given_name_c  = $urandom();
		c.family_name_a = {$urandom(), $urandom()};
		c.family_name_b = {$urandom(), $urandom()};
		c.family_name_c = $urandom();
		c.read_position = 4'($urandom_range(15));
		pick = $urandom_range(99);
		if (sb.count > 0 && pick < 55) begin
			row = $urandom_range(sb.count - 1);
			c.key_upper = sb.rows[row].key_upper;
			c.key_lower = sb.rows[row].key_lower;
			// near miss: one key bit off
			if ($urandom_range(9) == 0)
				{c.key_upper, c.key_lower} = {c.key_upper, c.key_lower} ^
					(88'd1 << $urandom_range(87));
		end else if (pick < 65) begin
			c.key_upper = '0;
			c.key_lower = '0;
		end else if (pick < 70) begin
			c.key_upper = '1;
			c.key_lower = '1;
		end else begin
			c.key_upper = {$urandom(), $urandom()};
			c.key_lower = 24'($urandom());
		end
		pick = $urandom_range(99);
		if (pick < add_pct) begin
			c.operation = OP_ADD;
		end else begin
			case ($urandom_range(2))
				0:       c.operation = OP_FIND;
				1:       c.operation = OP_REMOVE;
				default: c.operation = OP_READ;
			endcase
		end
		return c;
	endfunction

	function automatic cmd_t keyed(op_t op, logic [63:0] ku, logic [23:0] kl);
		cmd_t c;
		c           = random_cmd(0);
		c.operation = op;
		c.key_upper = ku;
		c.key_lower = kl;
		return c;
	endfunction

	task automatic send(cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
	endtask

	initial begin
		cmd_t c;
		int   add_pct;
		sb             = new();
		arst_n         = 1'b0;
		cmd_valid      = 1'b0;
		cmd            = '0;
		res_stall      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_go        = 1'b0;
		add_pct        = 45;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty table: reads return zero entries, zero-key searches must miss
		c = keyed(OP_READ, '0, '0);
		c.read_position = '0;
		send(c);
		c.read_position = '1;
		send(c);
		send(keyed(OP_FIND, '0, '0));
		send(keyed(OP_REMOVE, '0, '0));

		c = keyed(OP_ADD, '0, '0);
		c.given_name_a  = '0;
		c.given_name_b  = '0;
		c.given_name_c  = '0;
		c.family_name_a = '0;
		c.family_name_b = '0;
		c.family_name_c = '0;
		send(c);
		c = keyed(OP_ADD, '1, '1);
		c.given_name_a  = '1;
		c.given_name_b  = '1;
		c.given_name_c  = '1;
		c.family_name_a = '1;
		c.family_name_b = '1;
		c.family_name_c = '1;
		send(c);
		send(keyed(OP_FIND, '0, '0));
		send(keyed(OP_FIND, '1, '1));

		// fill up, with one duplicate key, then add once more
		for (int i = 0; i < ENTRIES - 2; i++) begin
			c = random_cmd(100);
			if (i == 5) {c.key_upper, c.key_lower} = '1;
			send(c);
		end
		send(random_cmd(100));
		send(keyed(OP_FIND, sb.rows[ENTRIES - 1].key_upper, sb.rows[ENTRIES - 1].key_lower));
		send(keyed(OP_FIND, '1, '1));

		// remove first, middle and last
		send(keyed(OP_REMOVE, '0, '0));
		send(keyed(OP_REMOVE, sb.rows[7].key_upper, sb.rows[7].key_lower));
		send(keyed(OP_REMOVE, sb.rows[sb.count - 1].key_upper,
			sb.rows[sb.count - 1].key_lower));
		c = keyed(OP_READ, '0, '0);
		c.read_position = 4'd15;
		send(c);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 100 == 0) begin
				case ((i / 100) % 4)
					0: begin
						send_idle_pct  = 0;
						recv_stall_pct = 0;
					end
					1: begin
						send_idle_pct  = 82;
						recv_stall_pct = 0;
					end
					2: begin
						send_idle_pct  = 0;
						recv_stall_pct = 82;
					end
					default: begin
						send_idle_pct  = 21;
						recv_stall_pct = 21;
					end
				endcase
			end
			if (i % 50 == 0) begin
				case ($urandom_range(2))
					0:       add_pct = 25;
					1:       add_pct = 45;
					default: add_pct = 70;
				endcase
			end
			if (i == 450) hold_go = 1'b1;
			send(random_cmd(add_pct));
		end
		cmd_valid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// File: filelist.f
sv/krt_pkg.sv
sv/krt_ram.sv
sv/keyed_record_table_unit.sv
tb/keyed_record_table_unit_tb.sv
